// ===== rtl/core/rstt_pkg.sv =====
// Shared widths, codes, types and split-multiply helpers for the
// segment-versus-triangle test pipeline. No dependencies.
`default_nettype none

package rstt_pkg;

    // Coordinate format: signed Q11.10, x in the lowest bits.
    localparam int COORD_BITS = 21;
    localparam int FIELD_W    = 63;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COPLANAR = 1'b1;

    localparam int CB    = COORD_BITS;
    localparam int E_W   = CB + 1;               // edges, P - A
    localparam int N_W   = 2 * E_W + 1;          // normal components
    localparam int MW    = N_W + E_W + 2;        // plane dot products, wide operand
    localparam int PW    = 2 * MW;               // full wide product
    localparam int LO_W  = MW / 2;
    localparam int HI_W  = MW - LO_W;
    localparam int PPW   = 2 * HI_W + 2;         // one partial product
    localparam int Q_W   = CB;                   // rounded quotient
    localparam int REM_W = MW + CB + 1;          // divider remainder
    localparam int H_W   = CB + 2;               // unsaturated plane point
    localparam int W_W   = CB + 3;               // plane point minus A
    localparam int G_W   = W_W + E_W + 2;        // barycentric dot products
    localparam int NPP   = 8;                    // wide products in flight per stage

    localparam int PP_LL = 0;
    localparam int PP_LH = 1;
    localparam int PP_HL = 2;
    localparam int PP_HH = 3;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MISS     = 3'd2,
        ST_COPLANAR = 3'd3,
        ST_DEGEN    = 3'd4
    } status_t;

    typedef logic [2:0][CB-1:0]    cvec_t;
    typedef logic [2:0][E_W-1:0]   evec_t;
    typedef logic [2:0][N_W-1:0]   nvec_t;
    typedef logic [2:0][H_W-1:0]   hvec_t;
    typedef logic [2:0][W_W-1:0]   wvec_t;
    typedef logic [2:0][REM_W-1:0] rvec_t;
    typedef logic [2:0][Q_W-1:0]   qvec_t;
    typedef logic [3:0][PPW-1:0]   pp4_t;

    typedef struct packed {
        cvec_t                   p;
        cvec_t                   d;
        cvec_t                   va;
        evec_t                   u;
        evec_t                   v;
        evec_t                   pa;
        nvec_t                   n;
        logic [G_W-1:0]          uu;
        logic [G_W-1:0]          uv;
        logic [G_W-1:0]          vv;
        logic [G_W-1:0]          wu;
        logic [G_W-1:0]          wv;
        pp4_t [NPP-1:0]          pp;
        logic [NPP-1:0][PW-1:0]  prod;
        logic [PW-1:0]           dd;
        logic [PW-1:0]           sn;
        logic [PW-1:0]           tn;
        logic [MW-1:0]           num;
        logic [MW-1:0]           den;
        logic                    degen;
        logic                    early;
        status_t                 st;
        logic [2:0]              dneg;
        rvec_t                   rem;
        qvec_t                   q;
        hvec_t                   h;
        wvec_t                   w;
        logic [3*CB-1:0]         hp;
    } pipe_t;

    // Split a signed product into four partial products of half width.
    function automatic pp4_t mul_split(input logic signed [MW-1:0] a,
                                       input logic signed [MW-1:0] b);
        logic signed [HI_W-1:0] ah;
        logic signed [HI_W-1:0] bh;
        logic signed [LO_W:0]   al;
        logic signed [LO_W:0]   bl;
        logic signed [PPW-1:0]  hh;
        logic signed [PPW-1:0]  hl;
        logic signed [PPW-1:0]  lh;
        logic signed [PPW-1:0]  ll;
        pp4_t                   r;
        ah = a[MW-1:LO_W];
        bh = b[MW-1:LO_W];
        al = {1'b0, a[LO_W-1:0]};
        bl = {1'b0, b[LO_W-1:0]};
        hh = ah * bh;
        hl = ah * bl;
        lh = al * bh;
        ll = al * bl;
        r[PP_HH] = hh;
        r[PP_HL] = hl;
        r[PP_LH] = lh;
        r[PP_LL] = ll;
        return r;
    endfunction

    // Recombine the partial products into the full signed product.
    function automatic logic signed [PW-1:0] mul_join(input pp4_t r);
        logic signed [PW-1:0] hh;
        logic signed [PW-1:0] hl;
        logic signed [PW-1:0] lh;
        logic signed [PW-1:0] ll;
        hh = PW'($signed(r[PP_HH]));
        hl = PW'($signed(r[PP_HL]));
        lh = PW'($signed(r[PP_LH]));
        ll = PW'($signed(r[PP_LL]));
        return (hh <<< (2 * LO_W)) + ((hl + lh) <<< LO_W) + ll;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ray_segment_triangle_test.sv =====
// Top level of the segment-versus-triangle test: a fixed-latency pipeline.
// Depends on rstt_pkg for widths, status codes, stage record and multiply helpers.
`default_nettype none

//  channel   ports                                        direction  accept
//  ------    -----                                        ---------  ------
//  item in   start, busy, ray_origin, ray_step,           in         start && !busy
//            vertex_a, vertex_b, vertex_c
//  result    done, status, hit_point                      out        done (one cycle)
//  config    cfg_we, cfg_index, cfg_data                  in         cfg_we
//
//  One item enters per cycle; busy stays low, the pipeline never stalls.
//  The bit-per-stage divider for the rounded plane point makes up most of the
//  pipeline (one quotient bit per stage, COORD_BITS stages).
//  Reset clears the valid chain and both thresholds; data registers carry no reset.
//  The receiver cannot stall: each result shows for exactly one cycle on done.

module ray_segment_triangle_test
    import rstt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FIELD_W-1:0]   ray_origin,
    input  logic [FIELD_W-1:0]   ray_step,
    input  logic [FIELD_W-1:0]   vertex_a,
    input  logic [FIELD_W-1:0]   vertex_b,
    input  logic [FIELD_W-1:0]   vertex_c,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [2:0]           status,
    output logic [FIELD_W-1:0]   hit_point
);

    // Stage map
    localparam int S_IN    = 0;              // unpack, edges, P - A
    localparam int S_NRM   = 1;              // normal, edge Gram terms
    localparam int S_SPL   = 2;              // split plane and Gram products
    localparam int S_JOIN  = 3;              // join them
    localparam int S_DOT   = 4;              // num, den, Gram determinant
    localparam int S_DEC   = 5;              // degenerate, parallel, range decisions
    localparam int S_SPL2  = 6;              // split num * |d|
    localparam int S_JOIN2 = 7;
    localparam int S_MAG   = 8;              // dividend setup
    localparam int S_DIV0  = 9;              // first divider stage
    localparam int S_HIT   = S_DIV0 + Q_W;   // plane point, saturation
    localparam int S_WD    = S_HIT + 1;      // w.u, w.v
    localparam int S_SPL3  = S_WD + 1;
    localparam int S_JOIN3 = S_SPL3 + 1;
    localparam int S_BARY  = S_JOIN3 + 1;    // s and t numerators
    localparam int S_OUT   = S_BARY + 1;     // final status
    localparam int NST     = S_OUT + 1;
    localparam int LAT     = S_OUT + 1;

    localparam logic signed [H_W-1:0] SAT_HI = H_W'((1 << (CB - 1)) - 1);
    localparam logic signed [H_W-1:0] SAT_LO = -SAT_HI - H_W'(1);

    logic [CFG_W-1:0] par_thr_reg;
    logic [CFG_W-1:0] par_thr_next;
    logic [CFG_W-1:0] cop_thr_reg;
    logic [CFG_W-1:0] cop_thr_next;

    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   vld_next;
    pipe_t            pipe_reg  [NST];
    pipe_t            pipe_next [NST];

    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------------------------------------------------------- config
    always_comb
    begin
        par_thr_next = par_thr_reg;
        cop_thr_next = cop_thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PARALLEL: par_thr_next = cfg_data;
                CFG_COPLANAR: cop_thr_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_thr_reg <= '0;
            cop_thr_reg <= '0;
            vld_reg     <= '0;
        end
        else
        begin
            par_thr_reg <= par_thr_next;
            cop_thr_reg <= cop_thr_next;
            vld_reg     <= vld_next;
        end
    end

    // Valid bits advance one stage per cycle alongside the data.
    assign vld_next = {vld_reg[NST-2:0], accept};

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
        begin
            pipe_reg[s] <= pipe_next[s];
        end
    end

    // ---------------------------------------------------------------- stage: unpack
    // Take coordinates apart and form the edge vectors and P - A.
    always_comb
    begin
        logic signed [CB-1:0] pk;
        logic signed [CB-1:0] ak;
        logic signed [CB-1:0] bk;
        logic signed [CB-1:0] ck;
        pipe_next[S_IN] = pipe_reg[S_IN];
        for (int k = 0; k < 3; k++)
        begin
            pk = ray_origin[k*CB +: CB];
            ak = vertex_a[k*CB +: CB];
            bk = vertex_b[k*CB +: CB];
            ck = vertex_c[k*CB +: CB];
            pipe_next[S_IN].p[k]  = pk;
            pipe_next[S_IN].d[k]  = ray_step[k*CB +: CB];
            pipe_next[S_IN].va[k] = ak;
            pipe_next[S_IN].u[k]  = E_W'(bk) - E_W'(ak);
            pipe_next[S_IN].v[k]  = E_W'(ck) - E_W'(ak);
            pipe_next[S_IN].pa[k] = E_W'(pk) - E_W'(ak);
        end
    end

    // ---------------------------------------------------------------- stage: normal
    always_comb
    begin
        pipe_t                c;
        logic signed [E_W-1:0] u0, u1, u2, v0, v1, v2;
        logic signed [N_W-1:0] n0, n1, n2;
        logic signed [G_W-1:0] uu, uv, vv;
        c  = pipe_reg[S_NRM-1];
        u0 = c.u[0];
        u1 = c.u[1];
        u2 = c.u[2];
        v0 = c.v[0];
        v1 = c.v[1];
        v2 = c.v[2];
        n0 = u1 * v2 - u2 * v1;
        n1 = u2 * v0 - u0 * v2;
        n2 = u0 * v1 - u1 * v0;
        uu = u0 * u0 + u1 * u1 + u2 * u2;
        uv = u0 * v0 + u1 * v1 + u2 * v2;
        vv = v0 * v0 + v1 * v1 + v2 * v2;
        c.n[0] = n0;
        c.n[1] = n1;
        c.n[2] = n2;
        c.uu   = uu;
        c.uv   = uv;
        c.vv   = vv;
        pipe_next[S_NRM] = c;
    end

    // ---------------------------------------------------------------- stage: split
    always_comb
    begin
        pipe_t c;
        c = pipe_reg[S_SPL-1];
        c.degen = (c.n == '0);
        for (int k = 0; k < 3; k++)
        begin
            c.pp[k]     = mul_split(MW'($signed(c.n[k])), MW'($signed(c.pa[k])));
            c.pp[3 + k] = mul_split(MW'($signed(c.n[k])), MW'($signed(c.d[k])));
        end
        c.pp[6] = mul_split(MW'($signed(c.uv)), MW'($signed(c.uv)));
        c.pp[7] = mul_split(MW'($signed(c.uu)), MW'($signed(c.vv)));
        pipe_next[S_SPL] = c;
    end

    always_comb
    begin
        pipe_t c;
        c = pipe_reg[S_JOIN-1];
        for (int j = 0; j < NPP; j++)
        begin
            c.prod[j] = mul_join(c.pp[j]);
        end
        pipe_next[S_JOIN] = c;
    end

    // ---------------------------------------------------------------- stage: dots
    // num = -n.(P-A), den = n.d, dd = uv^2 - uu*vv
    always_comb
    begin
        pipe_t                c;
        logic signed [PW-1:0] sumn;
        logic signed [PW-1:0] sumd;
        c    = pipe_reg[S_DOT-1];
        sumn = $signed(c.prod[0]) + $signed(c.prod[1]) + $signed(c.prod[2]);
        sumd = $signed(c.prod[3]) + $signed(c.prod[4]) + $signed(c.prod[5]);
        c.num = MW'(-sumn);
        c.den = MW'(sumd);
        c.dd  = $signed(c.prod[6]) - $signed(c.prod[7]);
        pipe_next[S_DOT] = c;
    end

    // ---------------------------------------------------------------- stage: decide
    // Degenerate first, then parallel/coplanar, then plane behind or beyond.
    always_comb
    begin
        pipe_t                c;
        logic signed [MW-1:0] nn;
        logic signed [MW-1:0] dn;
        logic [MW-1:0]        an;
        logic [MW-1:0]        ad;
        logic                 par;
        logic                 cop;
        c   = pipe_reg[S_DEC-1];
        nn  = c.num;
        dn  = c.den;
        ad  = dn[MW-1] ? MW'(-dn) : MW'(dn);
        an  = nn[MW-1] ? MW'(-nn) : MW'(nn);
        par = (ad <= MW'(par_thr_reg));
        cop = (an <= MW'(cop_thr_reg));
        if (dn[MW-1])
        begin
            dn = -dn;
            nn = -nn;
        end
        c.early = 1'b0;
        c.st    = ST_HIT;
        if (c.degen)
        begin
            c.early = 1'b1;
            c.st    = ST_DEGEN;
        end
        else if (par)
        begin
            c.early = 1'b1;
            c.st    = cop ? ST_COPLANAR : ST_MISS;
        end
        else if (nn[MW-1])
        begin
            c.early = 1'b1;
            c.st    = ST_MISS;
        end
        else if (dn < nn)
        begin
            c.early = 1'b1;
            c.st    = ST_SHORT;
        end
        c.num = nn;
        c.den = dn;
        pipe_next[S_DEC] = c;
    end

    // ---------------------------------------------------------------- stage: num * |d|
    always_comb
    begin
        pipe_t                c;
        logic signed [MW-1:0] dk;
        c = pipe_reg[S_SPL2-1];
        for (int k = 0; k < 3; k++)
        begin
            dk        = MW'($signed(c.d[k]));
            c.dneg[k] = c.d[k][CB-1];
            if (c.dneg[k])
            begin
                dk = -dk;
            end
            c.pp[k] = mul_split($signed(c.num), dk);
        end
        pipe_next[S_SPL2] = c;
    end

    always_comb
    begin
        pipe_t c;
        c = pipe_reg[S_JOIN2-1];
        for (int j = 0; j < 3; j++)
        begin
            c.prod[j] = mul_join(c.pp[j]);
        end
        pipe_next[S_JOIN2] = c;
    end

    // Dividend 2|num*d| + den over divisor 2*den rounds to nearest, ties away.
    always_comb
    begin
        pipe_t c;
        c = pipe_reg[S_MAG-1];
        for (int k = 0; k < 3; k++)
        begin
            c.rem[k] = (REM_W'(c.prod[k]) << 1) + REM_W'(c.den);
            c.q[k]   = '0;
        end
        pipe_next[S_MAG] = c;
    end

    // ---------------------------------------------------------------- divider
    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        localparam int QB = Q_W - 1 - j;
        always_comb
        begin
            pipe_t            c;
            logic [REM_W-1:0] dv;
            c  = pipe_reg[S_DIV0 + j - 1];
            dv = REM_W'(c.den) << (QB + 1);
            for (int k = 0; k < 3; k++)
            begin
                if (c.rem[k] >= dv)
                begin
                    c.rem[k]   = c.rem[k] - dv;
                    c.q[k][QB] = 1'b1;
                end
            end
            pipe_next[S_DIV0 + j] = c;
        end
    end

    // ---------------------------------------------------------------- stage: plane point
    always_comb
    begin
        pipe_t                c;
        logic signed [H_W-1:0] qs;
        logic signed [H_W-1:0] hk;
        logic signed [H_W-1:0] hc;
        c = pipe_reg[S_HIT-1];
        for (int k = 0; k < 3; k++)
        begin
            qs = H_W'($signed({1'b0, c.q[k]}));
            hk = H_W'($signed(c.p[k])) + (c.dneg[k] ? -qs : qs);
            hc = (hk > SAT_HI) ? SAT_HI : ((hk < SAT_LO) ? SAT_LO : hk);
            c.h[k] = hk;
            c.w[k] = W_W'(hk) - W_W'($signed(c.va[k]));
            c.hp[k*CB +: CB] = c.early ? '0 : CB'(hc);
        end
        pipe_next[S_HIT] = c;
    end

    // ---------------------------------------------------------------- barycentric
    always_comb
    begin
        pipe_t                 c;
        logic signed [G_W-1:0] wu;
        logic signed [G_W-1:0] wv;
        c  = pipe_reg[S_WD-1];
        wu = '0;
        wv = '0;
        for (int k = 0; k < 3; k++)
        begin
            wu = wu + $signed(c.w[k]) * $signed(c.u[k]);
            wv = wv + $signed(c.w[k]) * $signed(c.v[k]);
        end
        c.wu = wu;
        c.wv = wv;
        pipe_next[S_WD] = c;
    end

    always_comb
    begin
        pipe_t c;
        c = pipe_reg[S_SPL3-1];
        c.pp[0] = mul_split(MW'($signed(c.uv)), MW'($signed(c.wv)));
        c.pp[1] = mul_split(MW'($signed(c.vv)), MW'($signed(c.wu)));
        c.pp[2] = mul_split(MW'($signed(c.uv)), MW'($signed(c.wu)));
        c.pp[3] = mul_split(MW'($signed(c.uu)), MW'($signed(c.wv)));
        pipe_next[S_SPL3] = c;
    end

    always_comb
    begin
        pipe_t c;
        c = pipe_reg[S_JOIN3-1];
        for (int j = 0; j < 4; j++)
        begin
            c.prod[j] = mul_join(c.pp[j]);
        end
        pipe_next[S_JOIN3] = c;
    end

    always_comb
    begin
        pipe_t c;
        c    = pipe_reg[S_BARY-1];
        c.sn = $signed(c.prod[0]) - $signed(c.prod[1]);
        c.tn = $signed(c.prod[2]) - $signed(c.prod[3]);
        pipe_next[S_BARY] = c;
    end

    // Inside when s and t within bounds; dd is negative, so the signs flip.
    always_comb
    begin
        pipe_t                c;
        logic signed [PW-1:0] sn;
        logic signed [PW-1:0] tn;
        logic signed [PW-1:0] dd;
        c  = pipe_reg[S_OUT-1];
        sn = c.sn;
        tn = c.tn;
        dd = c.dd;
        if (!c.early)
        begin
            if ((sn > 0) || (sn < dd) || (tn > 0) || ((sn + tn) < dd))
            begin
                c.st = ST_MISS;
            end
            else
            begin
                c.st = ST_HIT;
            end
        end
        pipe_next[S_OUT] = c;
    end

    // ---------------------------------------------------------------- results
    assign done      = vld_reg[S_OUT];
    assign status    = pipe_reg[S_OUT].st;
    assign hit_point = FIELD_W'(pipe_reg[S_OUT].hp);

    // ---------------------------------------------------------------- checks
    // A result appears only for an item taken a fixed latency earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without matching item");

    // No plane point for statuses decided before the plane is reached.
    a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_DEGEN || status == ST_COPLANAR || status == ST_SHORT))
        |-> (hit_point == '0))
        else $error("plane point on early status");

endmodule

`default_nettype wire
